// ===== rtl/aes128_gcm_aead_macros.svh =====
// Assertion macros for the AES-128-GCM block
`ifndef AES128_GCM_AEAD_MACROS_SVH
`define AES128_GCM_AEAD_MACROS_SVH

// implication in the same cycle
`define AGCM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication in the next cycle
`define AGCM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/agcm_pkg.sv =====
// Shared types, codes and AES helper functions
package agcm_pkg;

  localparam logic [1:0] CMD_AAD  = 2'd0;
  localparam logic [1:0] CMD_TEXT = 2'd1;
  localparam logic [1:0] CMD_FIN  = 2'd2;

  localparam logic [1:0] KIND_CIPHER = 2'd0;
  localparam logic [1:0] KIND_TAG    = 2'd1;
  localparam logic [1:0] KIND_PLAIN  = 2'd2;
  localparam logic [1:0] KIND_STAT   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_AUTH  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  localparam logic [2:0] REG_KEY_HI   = 3'd0;
  localparam logic [2:0] REG_KEY_LO   = 3'd1;
  localparam logic [2:0] REG_NONCE_HI = 3'd2;
  localparam logic [2:0] REG_NONCE_LO = 3'd3;
  localparam logic [2:0] REG_DIR      = 3'd4;

  localparam int SLOT_W = 6;

  typedef enum logic [1:0] {
    OP_ERR  = 2'd0,
    OP_AAD  = 2'd1,
    OP_TEXT = 2'd2,
    OP_FIN  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              start;
    logic              dir;
    logic [1:0]        status;
    logic [127:0]      data;
    logic [4:0]        nbytes;
    logic [31:0]       ctr;
    logic [SLOT_W-1:0] slot;
    logic              buf_we;
    logic [31:0]       aad_len;
    logic [31:0]       txt_len;
    logic [6:0]        rel;
    logic              rel_part;
  } cmd_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [127:0] data;
    logic [4:0]   cnt;
    logic         last;
    logic [1:0]   status;
  } res_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    case (rnd)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127-8*(w+4*c) -: 8] = SBOX[s[127-8*(w+4*((c+w)%4)) -: 8]];
      end
    end
    sub_shift = r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      r[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      r[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      r[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      r[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_columns = r;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    byte_mask = ~({128{1'b1}} >> {n, 3'b000});
  endfunction

endpackage

// ===== rtl/agcm_fifo.sv =====
// Small register queue
module agcm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end
endmodule

// ===== rtl/agcm_aes.sv =====
// Iterative AES-128 encryption, one round per cycle, key schedule on the fly
module agcm_aes import agcm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [127:0] blk,
  output logic         done,
  output logic [127:0] result
);
  logic         busy_r, done_r;
  logic [3:0]   rnd_r;
  logic [127:0] st_r, rk_r;
  logic [127:0] rk_nxt, sb, st_nxt;

  always_comb begin
    rk_nxt = key_step(rk_r, rcon(rnd_r));
    sb     = sub_shift(st_r);
    st_nxt = ((rnd_r == 4'd10) ? sb : mix_columns(sb)) ^ rk_nxt;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_r <= blk ^ key;
      rk_r <= key;
    end else if (busy_r) begin
      st_r <= st_nxt;
      rk_r <= rk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 4'd1;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 4'd1;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 4'd1;
        if (rnd_r == 4'd10) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = st_r;
endmodule

// ===== rtl/agcm_ghash.sv =====
// GF(2^128) multiplier, four bits of the operand per cycle
module agcm_ghash (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] x_in,
  input  logic [127:0] h_in,
  output logic         done,
  output logic [127:0] z
);
  localparam int DIGIT = 4;
  localparam int STEPS = 128 / DIGIT;
  localparam int CW    = $clog2(STEPS);

  logic         busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [127:0] x_r, v_r, z_r;
  logic [127:0] x_nxt, v_nxt, z_nxt;

  always_comb begin
    logic lsb;
    x_nxt = x_r;
    v_nxt = v_r;
    z_nxt = z_r;
    for (int j = 0; j < DIGIT; j++) begin
      if (x_nxt[127]) begin
        z_nxt = z_nxt ^ v_nxt;
      end
      lsb   = v_nxt[0];
      v_nxt = {1'b0, v_nxt[127:1]} ^ (lsb ? {8'hE1, 120'd0} : 128'd0);
      x_nxt = {x_nxt[126:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
      v_r <= h_in;
      z_r <= '0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      v_r <= v_nxt;
      z_r <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign z    = z_r;
endmodule

// ===== rtl/agcm_front.sv =====
// Input side: order and overflow checks, message bookkeeping, command build
module agcm_front import agcm_pkg::*; #(
  parameter int MAX_TEXT_BLOCKS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [1:0]   command,
  input  logic [63:0]  data_high,
  input  logic [63:0]  data_low,
  input  logic [4:0]   byte_count,
  input  logic         dir,
  input  logic         q_full,
  output logic         cmd_push,
  output cmd_t         cmd
);
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_AAD  = 3'b010,
    PH_TEXT = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] aad_r, aad_nxt, txt_r, txt_nxt, ctr_r, ctr_nxt;
  logic        accept, bad_n, ooo, ovf, held_full;
  logic [27:0] held;
  logic [28:0] blocks;
  logic        part;

  assign accept    = push && !q_full;
  assign held      = txt_r[31:4];
  assign part      = (txt_r[3:0] != 4'd0);
  assign blocks    = {1'b0, held} + 29'(part);
  assign held_full = (held >= 28'(MAX_TEXT_BLOCKS));
  assign bad_n     = (byte_count == 5'd0) || (byte_count > 5'd16);

  always_comb begin
    ooo = 1'b0;
    ovf = 1'b0;
    case (command)
      CMD_AAD: begin
        ooo = bad_n || (phase_r == PH_TEXT) || (aad_r[3:0] != 4'd0);
        ovf = ({27'd0, byte_count} > ~aad_r);
      end
      CMD_TEXT: begin
        ooo = bad_n || ((phase_r == PH_TEXT) && part);
        ovf = ({27'd0, byte_count} > ~txt_r) || (dir && held_full);
      end
      CMD_FIN: ;
      default: ooo = 1'b1;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.start    = (phase_r == PH_IDLE);
    cmd.dir      = dir;
    cmd.status   = ST_OK;
    cmd.data     = {data_high, data_low};
    cmd.nbytes   = byte_count;
    cmd.ctr      = ctr_r;
    cmd.slot     = held[SLOT_W-1:0];
    cmd.buf_we   = !held_full;
    cmd.aad_len  = aad_r;
    cmd.txt_len  = txt_r;
    cmd.rel      = (blocks < 29'(MAX_TEXT_BLOCKS)) ? blocks[6:0] : 7'(MAX_TEXT_BLOCKS);
    cmd.rel_part = part && !held_full;
    phase_nxt    = phase_r;
    aad_nxt      = aad_r;
    txt_nxt      = txt_r;
    ctr_nxt      = ctr_r;
    if (ooo || ovf) begin
      cmd.op     = OP_ERR;
      cmd.start  = 1'b0;
      cmd.status = ooo ? ST_ORDER : ST_OVF;
    end else if (command == CMD_AAD) begin
      cmd.op    = OP_AAD;
      aad_nxt   = aad_r + {27'd0, byte_count};
      phase_nxt = PH_AAD;
    end else if (command == CMD_TEXT) begin
      cmd.op    = OP_TEXT;
      txt_nxt   = txt_r + {27'd0, byte_count};
      ctr_nxt   = ctr_r + 32'd1;
      phase_nxt = PH_TEXT;
    end else begin
      cmd.op    = OP_FIN;
      aad_nxt   = '0;
      txt_nxt   = '0;
      ctr_nxt   = 32'd2;
      phase_nxt = PH_IDLE;
    end
  end

  assign cmd_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      aad_r   <= '0;
      txt_r   <= '0;
      ctr_r   <= 32'd2;
    end else if (accept) begin
      phase_r <= phase_nxt;
      aad_r   <= aad_nxt;
      txt_r   <= txt_nxt;
      ctr_r   <= ctr_nxt;
    end
  end
endmodule

// ===== rtl/agcm_back.sv =====
// Execution side: AES, GHASH, plaintext buffer and result sequencing
module agcm_back import agcm_pkg::*; #(
  parameter int MAX_TEXT_BLOCKS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cq_empty,
  input  cmd_t         cq_data,
  output logic         cq_pop,
  input  logic [127:0] key,
  input  logic [95:0]  nonce,
  input  logic         oq_full,
  output logic         oq_push,
  output res_t         oq_data
);
  localparam int IDX_W = (MAX_TEXT_BLOCKS > 1) ? $clog2(MAX_TEXT_BLOCKS) : 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_LOAD   = 10'b0000000010,
    S_HSTART = 10'b0000000100,
    S_HKEY   = 10'b0000001000,
    S_PREP   = 10'b0000010000,
    S_KS     = 10'b0000100000,
    S_GH     = 10'b0001000000,
    S_EMIT   = 10'b0010000000,
    S_RD     = 10'b0100000000,
    S_WR     = 10'b1000000000
  } state_t;

  state_t       state_r, state_nxt;
  cmd_t         cmd_r;
  res_t         res_r, res_nxt, rel_res;
  logic [127:0] key_r, h_r, acc_r, acc_nxt;
  logic [6:0]   rk_r, rk_nxt;

  logic         aes_start, aes_done;
  logic [127:0] aes_blk, aes_out;
  logic         gh_start, gh_done;
  logic [127:0] gh_x, gh_z;

  logic [127:0] buf_r [MAX_TEXT_BLOCKS];
  logic [127:0] rd_q;
  logic         buf_we;
  logic [127:0] msk, din, ks, ct, pt, tag;

  agcm_aes u_aes (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (aes_start),
    .key    (key_r),
    .blk    (aes_blk),
    .done   (aes_done),
    .result (aes_out)
  );

  agcm_ghash u_ghash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gh_start),
    .x_in  (gh_x),
    .h_in  (h_r),
    .done  (gh_done),
    .z     (gh_z)
  );

  always_comb begin
    msk = byte_mask(cmd_r.nbytes);
    din = cmd_r.data & msk;
    ks  = aes_out & msk;
    ct  = cmd_r.dir ? din : din ^ ks;
    pt  = cmd_r.dir ? din ^ ks : din;
    tag = aes_out ^ acc_r;
  end

  always_comb begin
    rel_res        = '0;
    rel_res.kind   = KIND_PLAIN;
    rel_res.data   = rd_q;
    rel_res.last   = (rk_r + 7'd1 == cmd_r.rel);
    rel_res.cnt    = (rel_res.last && cmd_r.rel_part) ? {1'b0, cmd_r.txt_len[3:0]} : 5'd16;
    rel_res.status = ST_OK;
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    acc_nxt   = acc_r;
    rk_nxt    = rk_r;
    cq_pop    = 1'b0;
    aes_start = 1'b0;
    aes_blk   = '0;
    gh_start  = 1'b0;
    gh_x      = acc_r ^ din;
    buf_we    = 1'b0;
    oq_push   = 1'b0;
    oq_data   = res_r;
    case (state_r)
      S_IDLE: begin
        if (!cq_empty) begin
          cq_pop    = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (cmd_r.op == OP_ERR) begin
          res_nxt   = '{kind: KIND_STAT, data: '0, cnt: 5'd0, last: 1'b0,
                        status: cmd_r.status};
          state_nxt = S_EMIT;
        end else if (cmd_r.start) begin
          state_nxt = S_HSTART;
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_HSTART: begin
        aes_start = 1'b1;
        state_nxt = S_HKEY;
      end
      S_HKEY: begin
        if (aes_done) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (cmd_r.op == OP_TEXT) begin
          aes_start = 1'b1;
          aes_blk   = {nonce, cmd_r.ctr};
          state_nxt = S_KS;
        end else begin
          gh_start = 1'b1;
          if (cmd_r.op == OP_FIN) begin
            gh_x = acc_r ^ {29'd0, cmd_r.aad_len, 3'd0, 29'd0, cmd_r.txt_len, 3'd0};
          end
          state_nxt = S_GH;
        end
      end
      S_KS: begin
        if (aes_done) begin
          if (cmd_r.op == OP_TEXT) begin
            gh_start  = 1'b1;
            gh_x      = acc_r ^ ct;
            buf_we    = cmd_r.buf_we;
            res_nxt   = '{kind: KIND_CIPHER, data: ct, cnt: cmd_r.nbytes, last: 1'b0,
                          status: ST_OK};
            state_nxt = S_GH;
          end else begin
            acc_nxt   = '0;
            state_nxt = S_EMIT;
            rk_nxt    = '0;
            if (!cmd_r.dir) begin
              res_nxt = '{kind: KIND_TAG, data: tag, cnt: 5'd16, last: 1'b1, status: ST_OK};
            end else if (tag != cmd_r.data) begin
              res_nxt = '{kind: KIND_STAT, data: '0, cnt: 5'd0, last: 1'b1, status: ST_AUTH};
            end else if (cmd_r.rel == 7'd0) begin
              res_nxt = '{kind: KIND_STAT, data: '0, cnt: 5'd0, last: 1'b1, status: ST_OK};
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_GH: begin
        if (gh_done) begin
          acc_nxt = gh_z;
          if (cmd_r.op == OP_FIN) begin
            aes_start = 1'b1;
            aes_blk   = {nonce, 32'd1};
            state_nxt = S_KS;
          end else if (cmd_r.op == OP_TEXT && !cmd_r.dir) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (!oq_full) begin
          oq_push   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        oq_data = rel_res;
        if (!oq_full) begin
          oq_push   = 1'b1;
          rk_nxt    = rk_r + 7'd1;
          state_nxt = rel_res.last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[cmd_r.slot[IDX_W-1:0]] <= pt;
    end
    if (state_r == S_RD) begin
      rd_q <= buf_r[rk_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cmd_r <= cq_data;
    end
    if (state_r == S_LOAD && cmd_r.start) begin
      key_r <= key;
    end
    if (state_r == S_HKEY && aes_done) begin
      h_r <= aes_out;
    end
    res_r <= res_nxt;
    rk_r  <= rk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
    end
  end
endmodule

// ===== rtl/aes128_gcm_aead.sv =====
// AES-128-GCM seal/open; the first command of a message also derives the hash key.
// Time per item is set by the iterative AES core and the 4-bit-per-cycle
// GHASH multiplier; they run one after the other for a text block and a finish.
// An open-mode release reads each plaintext block from the buffer (S_RD), then pushes it (S_WR).
// A two-entry command queue lets input be taken while the back end works.
// Synchronous active-low reset clears control state and config registers; no clearing pass.
module aes128_gcm_aead import agcm_pkg::*; #(
  parameter int MAX_TEXT_BLOCKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  input  logic [4:0]  in_byte_count,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [63:0] out_data_high,
  output logic [63:0] out_data_low,
  output logic [4:0]  out_byte_count,
  output logic        out_last,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  `include "aes128_gcm_aead_macros.svh"

  logic [63:0] key_hi_r, key_lo_r, nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic        dir_r;

  logic cq_push, cq_full, cq_pop, cq_empty;
  cmd_t cq_wdata, cq_rdata;
  logic oq_push, oq_full;
  res_t oq_wdata, oq_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r   <= '0;
      key_lo_r   <= '0;
      nonce_hi_r <= '0;
      nonce_lo_r <= '0;
      dir_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HI:   key_hi_r   <= cfg_data;
        REG_KEY_LO:   key_lo_r   <= cfg_data;
        REG_NONCE_HI: nonce_hi_r <= cfg_data[31:0];
        REG_NONCE_LO: nonce_lo_r <= cfg_data;
        REG_DIR:      dir_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  agcm_front #(.MAX_TEXT_BLOCKS(MAX_TEXT_BLOCKS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .command    (in_command),
    .data_high  (in_data_high),
    .data_low   (in_data_low),
    .byte_count (in_byte_count),
    .dir        (dir_r),
    .q_full     (cq_full),
    .cmd_push   (cq_push),
    .cmd        (cq_wdata)
  );

  agcm_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cq_push),
    .wr_data (cq_wdata),
    .full    (cq_full),
    .pop     (cq_pop),
    .rd_data (cq_rdata),
    .empty   (cq_empty)
  );

  agcm_back #(.MAX_TEXT_BLOCKS(MAX_TEXT_BLOCKS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_data  (cq_rdata),
    .cq_pop   (cq_pop),
    .key      ({key_hi_r, key_lo_r}),
    .nonce    ({nonce_hi_r, nonce_lo_r}),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata)
  );

  agcm_fifo #(.W($bits(res_t)), .DEPTH(2)) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_data (oq_wdata),
    .full    (oq_full),
    .pop     (out_pop),
    .rd_data (oq_rdata),
    .empty   (out_empty)
  );

  assign in_full        = cq_full;
  assign out_kind       = oq_rdata.kind;
  assign out_data_high  = oq_rdata.data[127:64];
  assign out_data_low   = oq_rdata.data[63:0];
  assign out_byte_count = oq_rdata.cnt;
  assign out_last       = oq_rdata.last;
  assign out_status     = oq_rdata.status;

  `AGCM_ASSERT_IMP(a_cmdq_no_overrun, cq_push, !cq_full)
  `AGCM_ASSERT_IMP(a_cmdq_no_underrun, cq_pop, !cq_empty)
  `AGCM_ASSERT_IMP(a_outq_no_overrun, oq_push, !oq_full)
  `AGCM_ASSERT_NXT(a_outq_fills, oq_push && out_empty, !out_empty)
endmodule
